// ----- sv/sef_pkg.sv -----
// Shared widths, pipeline records and result packing for the embedding evaluator.
`timescale 1ns / 1ps

package sef_pkg;

    // Fraction bits of density, coefficient and results
    localparam int FRAC_BITS = 16;

    localparam int DENS_W  = 32;
    localparam int COEFF_W = 32;
    localparam int OUT_W   = 48;

    // Root radicand is density << FRAC_BITS, padded to an even width
    localparam int RAD_W   = DENS_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SREM_W  = ROOT_W + 1;

    // Divider: numerators are |A| << F and |A| << 2F, largest divisor is 4*n*r
    localparam int NUM_W   = COEFF_W + 2 * FRAC_BITS;
    localparam int DEN_W   = 2 + DENS_W + ROOT_W;
    localparam int PROD_W  = COEFF_W + ROOT_W;
    localparam int NR_W    = DENS_W + ROOT_W;
    localparam int E_W     = PROD_W + 1 - FRAC_BITS;
    localparam int MAG_W   = NUM_W + 1;

    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(65536);
    localparam logic [MAG_W-1:0]   POS_LIM = MAG_W'((65'd1 << (OUT_W - 1)) - 65'd1);
    localparam logic [MAG_W-1:0]   NEG_LIM = MAG_W'(65'd1 << (OUT_W - 1));

    // Data held by one square-root cell
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [DENS_W-1:0] dens;
    } sq_cell_t;

    // Data held by one divider cell: word carries dividend bits out, quotient bits in
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] word;
    } div_cell_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } packed_res_t;

    // Clip a magnitude to the 48-bit range and apply the sign
    function automatic packed_res_t pack_res(input logic [MAG_W-1:0] mag, input logic neg);
        packed_res_t      res;
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        lim = neg ? NEG_LIM : POS_LIM;
        m = mag;
        res.sat = 1'b0;
        if (mag > lim)
        begin
            m = lim;
            res.sat = 1'b1;
        end
        res.val = neg ? OUT_W'(-m) : OUT_W'(m);
        return res;
    endfunction

endpackage

// ----- sv/sef_sqrt_cell.sv -----
// One restoring square-root cell: settles one root bit per cycle.
`timescale 1ns / 1ps

module sef_sqrt_cell
    import sef_pkg::*;
(
    input  logic     clk,
    input  sq_cell_t cell_in,
    output sq_cell_t cell_out
);

    logic [SREM_W+1:0] rem_s;
    logic [SREM_W+1:0] trial;
    logic              ge;
    sq_cell_t          cell_next;

    // Bring down two radicand bits and try root*4+1
    always_comb
    begin
        rem_s = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
        trial = (SREM_W + 2)'({cell_in.root, 2'b01});
        ge    = (rem_s >= trial);
        cell_next.rad  = {cell_in.rad[RAD_W-3:0], 2'b00};
        cell_next.rem  = ge ? SREM_W'(rem_s - trial) : rem_s[SREM_W-1:0];
        cell_next.root = {cell_in.root[ROOT_W-2:0], ge};
        cell_next.dens = cell_in.dens;
    end

    // Hand to the next cell
    always_ff @(posedge clk)
    begin
        cell_out <= cell_next;
    end

endmodule

// ----- sv/sef_div_cell.sv -----
// One restoring divider cell: settles one quotient bit per cycle.
`timescale 1ns / 1ps

module sef_div_cell
    import sef_pkg::*;
(
    input  logic      clk,
    input  div_cell_t cell_in,
    output div_cell_t cell_out
);

    logic [DEN_W:0] rem_s;
    logic [DEN_W:0] den_x;
    logic           ge;
    div_cell_t      cell_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        rem_s = {cell_in.rem, cell_in.word[NUM_W-1]};
        den_x = {1'b0, cell_in.den};
        ge    = (rem_s >= den_x);
        cell_next.den  = cell_in.den;
        cell_next.rem  = ge ? DEN_W'(rem_s - den_x) : rem_s[DEN_W-1:0];
        cell_next.word = {cell_in.word[NUM_W-2:0], ge};
    end

    // Hand to the next cell
    always_ff @(posedge clk)
    begin
        cell_out <= cell_next;
    end

endmodule

// ----- sv/sqrt_embedding_function_eval.sv -----
// Top level: square-root embedding energy with first and second derivatives.
//
//  channel   signals                                   direction  handshake
//  request   start, busy, density                      in         start && !busy
//  result    done, energy, first_deriv, second_deriv,  out        done, one cycle
//            saturated
//  config    cfg_valid, cfg_ready, cfg_data            in         cfg_valid && cfg_ready
//
// One request per clock; busy stays low. Each request passes through a chain of root
// cells, one multiply stage, a chain of divider cells one quotient bit each, and the
// output register.
// Reset clears the valid line and sets the coefficient to 1.0. The receiver
// cannot stall; results leave on done.
`timescale 1ns / 1ps

module sqrt_embedding_function_eval
    import sef_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [DENS_W-1:0]        density,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [COEFF_W-1:0] cfg_data,
    output logic                     done,
    output logic signed [OUT_W-1:0]  energy,
    output logic signed [OUT_W-1:0]  first_deriv,
    output logic signed [OUT_W-1:0]  second_deriv,
    output logic                     saturated
);

    logic [COEFF_W-1:0] coeff_reg;
    logic               a_neg;
    logic [COEFF_W-1:0] a_mag;

    sq_cell_t  sq_pipe [0:ROOT_W];
    logic      sq_vld_reg [1:ROOT_W];

    logic              m_vld_reg;
    logic              m_zero_reg;
    logic [PROD_W-1:0] m_prod_reg;
    logic [DEN_W-1:0]  m_den1_reg;
    logic [NR_W-1:0]   m_nr_reg;

    div_cell_t d1_pipe [0:NUM_W];
    div_cell_t d2_pipe [0:NUM_W];

    logic           side_vld_reg  [1:NUM_W];
    logic           side_zero_reg [1:NUM_W];
    logic [E_W-1:0] side_e_reg    [1:NUM_W];
    logic [PROD_W:0] e_sum;

    logic [MAG_W-1:0] mag_e;
    logic [MAG_W-1:0] mag_1;
    logic [MAG_W-1:0] mag_2;
    packed_res_t      res_e;
    packed_res_t      res_1;
    packed_res_t      res_2;

    logic               done_reg;
    logic [OUT_W-1:0]   energy_reg;
    logic [OUT_W-1:0]   d1_reg;
    logic [OUT_W-1:0]   d2_reg;
    logic               sat_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold the coefficient register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            coeff_reg <= cfg_data;
        end
    end

    assign a_neg = coeff_reg[COEFF_W-1];
    assign a_mag = a_neg ? (~coeff_reg + COEFF_W'(1)) : coeff_reg;

    // Feed the root chain from the request
    always_comb
    begin
        sq_pipe[0].rad  = RAD_W'({density, {FRAC_BITS{1'b0}}});
        sq_pipe[0].rem  = '0;
        sq_pipe[0].root = '0;
        sq_pipe[0].dens = density;
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_sq
            sef_sqrt_cell u_cell (
                .clk      (clk),
                .cell_in  (sq_pipe[k]),
                .cell_out (sq_pipe[k+1])
            );
        end
    endgenerate

    // Advance the valid line along the root chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= ROOT_W; i++)
            begin
                sq_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sq_vld_reg[1] <= start && !busy;
            for (int i = 2; i <= ROOT_W; i++)
            begin
                sq_vld_reg[i] <= sq_vld_reg[i-1];
            end
        end
    end

    // Multiply stage: energy product, divisors 2r and 4nr
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= sq_vld_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        m_zero_reg <= (sq_pipe[ROOT_W].dens == '0);
        m_prod_reg <= PROD_W'(a_mag) * PROD_W'(sq_pipe[ROOT_W].root);
        m_nr_reg   <= NR_W'(sq_pipe[ROOT_W].dens) * NR_W'(sq_pipe[ROOT_W].root);
        m_den1_reg <= DEN_W'({sq_pipe[ROOT_W].root, 1'b0});
    end

    // Feed both divider chains
    always_comb
    begin
        d1_pipe[0].den  = m_den1_reg;
        d1_pipe[0].rem  = '0;
        d1_pipe[0].word = NUM_W'(a_mag) << FRAC_BITS;
        d2_pipe[0].den  = {m_nr_reg, 2'b00};
        d2_pipe[0].rem  = '0;
        d2_pipe[0].word = NUM_W'(a_mag) << (2 * FRAC_BITS);
    end

    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_div
            sef_div_cell u_d1 (
                .clk      (clk),
                .cell_in  (d1_pipe[k]),
                .cell_out (d1_pipe[k+1])
            );
            sef_div_cell u_d2 (
                .clk      (clk),
                .cell_in  (d2_pipe[k]),
                .cell_out (d2_pipe[k+1])
            );
        end
    endgenerate

    // Round the energy and carry it alongside the dividers
    assign e_sum = (PROD_W + 1)'(m_prod_reg) + (PROD_W + 1)'(1 << (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NUM_W; i++)
            begin
                side_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            side_vld_reg[1] <= m_vld_reg;
            for (int i = 2; i <= NUM_W; i++)
            begin
                side_vld_reg[i] <= side_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_zero_reg[1] <= m_zero_reg;
        side_e_reg[1]    <= E_W'(e_sum >> FRAC_BITS);
        for (int i = 2; i <= NUM_W; i++)
        begin
            side_zero_reg[i] <= side_zero_reg[i-1];
            side_e_reg[i]    <= side_e_reg[i-1];
        end
    end

    // Round quotients half up, then clip and sign
    always_comb
    begin
        mag_e = MAG_W'(side_e_reg[NUM_W]);
        mag_1 = MAG_W'(d1_pipe[NUM_W].word)
              + MAG_W'({d1_pipe[NUM_W].rem, 1'b0} >= {1'b0, d1_pipe[NUM_W].den});
        mag_2 = MAG_W'(d2_pipe[NUM_W].word)
              + MAG_W'({d2_pipe[NUM_W].rem, 1'b0} >= {1'b0, d2_pipe[NUM_W].den});
        res_e = pack_res(mag_e, !a_neg);
        res_1 = pack_res(mag_1, !a_neg);
        res_2 = pack_res(mag_2, a_neg);
    end

    // Output register; drop everything to zero on zero density
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_vld_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (side_zero_reg[NUM_W])
        begin
            energy_reg <= '0;
            d1_reg     <= '0;
            d2_reg     <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            energy_reg <= res_e.val;
            d1_reg     <= res_1.val;
            d2_reg     <= res_2.val;
            sat_reg    <= res_e.sat | res_1.sat | res_2.sat;
        end
    end

    assign done         = done_reg;
    assign energy       = energy_reg;
    assign first_deriv  = d1_reg;
    assign second_deriv = d2_reg;
    assign saturated    = sat_reg;

endmodule
